FILE: sv/fbwt_pkg.sv
// fbwt_pkg: shared types and constants of the four-bone weight table
// no dependencies
`timescale 1ns / 1ps

package fbwt_pkg;

	localparam int BONE_W   = 8;
	localparam int WEIGHT_W = 16;
	localparam int VERTEX_W = 12;
	localparam int PAIR_W   = BONE_W + WEIGHT_W;
	localparam int SHOWN    = 4;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	typedef struct packed {
		logic                kind;
		logic [VERTEX_W-1:0] vertex_index;
		logic [BONE_W-1:0]   bone_index;
		logic [WEIGHT_W-1:0] weight;
	} item_t;

	typedef struct packed {
		logic [BONE_W-1:0]   bone_a;
		logic [BONE_W-1:0]   bone_b;
		logic [BONE_W-1:0]   bone_c;
		logic [BONE_W-1:0]   bone_d;
		logic [WEIGHT_W-1:0] weight_a;
		logic [WEIGHT_W-1:0] weight_b;
		logic [WEIGHT_W-1:0] weight_c;
		logic [WEIGHT_W-1:0] weight_d;
		logic                was_inserted;
	} result_t;

endpackage

FILE: sv/fbwt_row_mem.sv
// fbwt_row_mem: one row per vertex, registered read, clearing pass after reset
// depends on fbwt_pkg
`timescale 1ns / 1ps

module fbwt_row_mem #(
	parameter int VERTICES = 4096,
	parameter int SLOTS    = 4,
	parameter int AW       = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                rd_en,
	input  logic [AW-1:0]                       rd_addr,
	output logic [SLOTS*fbwt_pkg::PAIR_W-1:0]   rd_data,
	input  logic                                wr_en,
	input  logic [AW-1:0]                       wr_addr,
	input  logic [SLOTS*fbwt_pkg::PAIR_W-1:0]   wr_data,
	output logic                                clearing
);
	import fbwt_pkg::*;

	localparam int ROW_W = SLOTS * PAIR_W;

	logic [ROW_W-1:0] mem_q [VERTICES];
	logic [ROW_W-1:0] rd_data_q;
	logic             clearing_q;
	logic [AW-1:0]    clr_idx_q;

	logic             we;
	logic [AW-1:0]    wa;
	logic [ROW_W-1:0] wd;

	always_comb begin
		we = clearing_q ? 1'b1 : wr_en;
		wa = clearing_q ? clr_idx_q : wr_addr;
		wd = clearing_q ? '0 : wr_data;
	end

	// one row zeroed per cycle until the last vertex
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			if (clr_idx_q == AW'(VERTICES - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign clearing = clearing_q;

endmodule

FILE: sv/fbwt_insert.sv
// fbwt_insert: sorted insertion of one bone/weight pair into a vertex row
// depends on fbwt_pkg
`timescale 1ns / 1ps

module fbwt_insert #(
	parameter int SLOTS = 4
) (
	input  logic [SLOTS*fbwt_pkg::PAIR_W-1:0] row_in,
	input  logic [fbwt_pkg::BONE_W-1:0]       bone,
	input  logic [fbwt_pkg::WEIGHT_W-1:0]     weight,
	output logic [SLOTS*fbwt_pkg::PAIR_W-1:0] row_out,
	output logic                              inserted
);
	import fbwt_pkg::*;

	always_comb begin
		logic              found;
		logic [PAIR_W-1:0] prev;
		logic [PAIR_W-1:0] old;
		found   = 1'b0;
		prev    = '0;
		row_out = row_in;
		for (int j = 0; j < SLOTS; j++) begin
			old = row_in[j*PAIR_W +: PAIR_W];
			// slots below the insertion point take their upper neighbor
			if (found) begin
				row_out[j*PAIR_W +: PAIR_W] = prev;
			end else if (weight > old[WEIGHT_W-1:0]) begin
				row_out[j*PAIR_W +: PAIR_W] = {bone, weight};
				found = 1'b1;
			end
			prev = old;
		end
		inserted = found;
	end

endmodule

FILE: sv/top_four_bone_weight_table.sv
// top_four_bone_weight_table: per-vertex top-four bone influence table
// depends on fbwt_pkg, fbwt_row_mem, fbwt_insert
// path: an accepted item is registered into the s1 stage, then its result into done/result
// throughput: one word per cycle while not busy; a written row is forwarded to the next item
// reset: busy stays high while the row memory is zeroed
// the receiver cannot stall; every result is shown for exactly one cycle
`timescale 1ns / 1ps

module top_four_bone_weight_table #(
	parameter int VERTICES = 4096,
	parameter int SLOTS    = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  fbwt_pkg::item_t   item,
	output logic              done,
	output fbwt_pkg::result_t result
);
	import fbwt_pkg::*;

	localparam int AW    = (VERTICES > 1) ? $clog2(VERTICES) : 1;
	localparam int ROW_W = SLOTS * PAIR_W;

	logic             clearing;
	logic             accept;
	logic [31:0]      vx;
	logic [AW-1:0]    addr_in;
	logic             in_range;

	logic             v_s1;
	logic             ins_s1;
	logic             rng_s1;
	logic [AW-1:0]    addr_s1;
	logic [BONE_W-1:0]   bone_s1;
	logic [WEIGHT_W-1:0] weight_s1;

	logic             fwd_v_q;
	logic [AW-1:0]    fwd_addr_q;
	logic [ROW_W-1:0] fwd_row_q;

	logic [ROW_W-1:0] rd_data;
	logic [ROW_W-1:0] row_cur;
	logic [ROW_W-1:0] row_new;
	logic             inserted;
	logic             wr_en;
	logic [ROW_W-1:0] row_show;
	result_t          res_d;

	logic             done_q;
	result_t          result_q;

	assign busy    = clearing;
	assign accept  = start && !clearing;
	assign vx      = 32'(item.vertex_index);
	assign addr_in = vx[AW-1:0];
	assign in_range = vx < 32'(VERTICES);

	fbwt_row_mem #(
		.VERTICES(VERTICES),
		.SLOTS   (SLOTS),
		.AW      (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && in_range),
		.rd_addr (addr_in),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (row_new),
		.clearing(clearing)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ins_s1    <= (item.kind == KIND_INSERT);
			rng_s1    <= in_range;
			addr_s1   <= addr_in;
			bone_s1   <= item.bone_index;
			weight_s1 <= item.weight;
		end
	end

	// the memory read issued alongside a write sees the old row
	assign row_cur = (fwd_v_q && fwd_addr_q == addr_s1) ? fwd_row_q : rd_data;

	fbwt_insert #(
		.SLOTS(SLOTS)
	) u_insert (
		.row_in  (row_cur),
		.bone    (bone_s1),
		.weight  (weight_s1),
		.row_out (row_new),
		.inserted(inserted)
	);

	assign wr_en = v_s1 && rng_s1 && ins_s1 && inserted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
		end else begin
			fwd_v_q <= wr_en;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= addr_s1;
			fwd_row_q  <= row_new;
		end
	end

	always_comb begin
		logic [SHOWN*BONE_W-1:0]   bones;
		logic [SHOWN*WEIGHT_W-1:0] weights;
		logic [PAIR_W-1:0]         pair;
		bones    = '0;
		weights  = '0;
		row_show = (ins_s1 && rng_s1) ? row_new : row_cur;
		for (int k = 0; k < SHOWN; k++) begin
			pair = '0;
			if (k < SLOTS && rng_s1) begin
				pair = row_show[k*PAIR_W +: PAIR_W];
			end
			bones[k*BONE_W +: BONE_W]       = pair[PAIR_W-1 -: BONE_W];
			weights[k*WEIGHT_W +: WEIGHT_W] = pair[WEIGHT_W-1:0];
		end
		res_d.bone_a       = bones[0*BONE_W +: BONE_W];
		res_d.bone_b       = bones[1*BONE_W +: BONE_W];
		res_d.bone_c       = bones[2*BONE_W +: BONE_W];
		res_d.bone_d       = bones[3*BONE_W +: BONE_W];
		res_d.weight_a     = weights[0*WEIGHT_W +: WEIGHT_W];
		res_d.weight_b     = weights[1*WEIGHT_W +: WEIGHT_W];
		res_d.weight_c     = weights[2*WEIGHT_W +: WEIGHT_W];
		res_d.weight_d     = weights[3*WEIGHT_W +: WEIGHT_W];
		res_d.was_inserted = wr_en;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			result_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

FILE: tb/sv/top_four_bone_weight_table_tb.sv
// top_four_bone_weight_table_tb: self-checking bench for the per-vertex top-four bone table
// depends on fbwt_pkg and top_four_bone_weight_table; directed rows, then random words
`timescale 1ns / 1ps

module top_four_bone_weight_table_tb;
	import fbwt_pkg::*;

	localparam int NUM_VERTICES = 4096;
	localparam int NUM_SLOTS    = 4;
	localparam int CLK_HALF     = 2;
	localparam int RESET_CYCLES = 5;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RAND_PER_PHASE = 175;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		item_t   word;
		logic    fixed;
		result_t answer;
	} stim_row_t;

	localparam result_t EMPTY_ROW = '0;
	localparam result_t V5_FIRST  = {8'hFF, 8'd0, 8'd0, 8'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 1'b1};
	localparam result_t V5_TIED   = {8'hFF, 8'd1, 8'd0, 8'd0,
		16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 1'b1};
	localparam int DIR_N = 21;

	localparam stim_row_t DIR_ROWS [0:DIR_N-1] = '{
		{{KIND_READ,   12'd0,    8'd0,   16'd0},     1'b1, EMPTY_ROW},
		{{KIND_READ,   12'hFFF,  8'hFF,  16'hFFFF},  1'b1, EMPTY_ROW},
		// zero weight never enters
		{{KIND_INSERT, 12'd0,    8'hFF,  16'd0},     1'b1, EMPTY_ROW},
		{{KIND_INSERT, 12'd5,    8'hFF,  16'hFFFF},  1'b1, V5_FIRST},
		// equal to the top weight: goes in just below it
		{{KIND_INSERT, 12'd5,    8'd1,   16'hFFFF},  1'b1, V5_TIED},
		{{KIND_INSERT, 12'd5,    8'd2,   16'd1},     1'b0, EMPTY_ROW},
		{{KIND_INSERT, 12'd5,    8'd3,   16'h8000},  1'b0, EMPTY_ROW},
		// tie lands below the stored equal weight
		{{KIND_INSERT, 12'd5,    8'd4,   16'h8000},  1'b0, EMPTY_ROW},
		{{KIND_INSERT, 12'd5,    8'd5,   16'd2},     1'b0, EMPTY_ROW},
		{{KIND_INSERT, 12'd5,    8'd6,   16'd1},     1'b0, EMPTY_ROW},
		{{KIND_INSERT, 12'd5,    8'd7,   16'h8001},  1'b0, EMPTY_ROW},
		{{KIND_READ,   12'd5,    8'd0,   16'd0},     1'b0, EMPTY_ROW},
		{{KIND_INSERT, 12'hFFF,  8'hAA,  16'h5555},  1'b0, EMPTY_ROW},
		{{KIND_INSERT, 12'hFFF,  8'h55,  16'hAAAA},  1'b0, EMPTY_ROW},
		{{KIND_INSERT, 12'hFFF,  8'h00,  16'hFFFF},  1'b0, EMPTY_ROW},
		{{KIND_INSERT, 12'hFFF,  8'h80,  16'h0001},  1'b0, EMPTY_ROW},
		{{KIND_INSERT, 12'hFFF,  8'h7F,  16'h7FFF},  1'b0, EMPTY_ROW},
		{{KIND_READ,   12'hFFF,  8'hFF,  16'hFFFF},  1'b0, EMPTY_ROW},
		{{KIND_INSERT, 12'hAAA,  8'h01,  16'h1234},  1'b0, EMPTY_ROW},
		{{KIND_INSERT, 12'h555,  8'hFE,  16'hEDCB},  1'b0, EMPTY_ROW},
		{{KIND_READ,   12'd0,    8'd0,   16'd0},     1'b1, EMPTY_ROW}
	};

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	item_t   item   = '0;
	logic    busy;
	logic    done;
	result_t result;

	logic [BONE_W-1:0]   bone_rows   [NUM_VERTICES][NUM_SLOTS];
	logic [WEIGHT_W-1:0] weight_rows [NUM_VERTICES][NUM_SLOTS];

	result_t     pending_results [$];
	stim_row_t   word_notes [$];
	int unsigned fail_count  = 0;
	int unsigned cycle_count = 0;

	top_four_bone_weight_table #(
		.VERTICES(NUM_VERTICES),
		.SLOTS(NUM_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	always #(CLK_HALF) clk = ~clk;

	// top-k insertion on one vertex row, returns the row as the block shows it
	function automatic result_t predict_word(item_t w);
		result_t r;
		int v;
		int s;
		int j;
		logic placed;
		v = w.vertex_index;
		placed = 1'b0;
		if (w.kind == KIND_INSERT) begin
			for (s = 0; s < NUM_SLOTS && !placed; s++) begin
				if (w.weight > weight_rows[v][s]) begin
					for (j = NUM_SLOTS - 1; j > s; j--) begin
						bone_rows[v][j]   = bone_rows[v][j-1];
						weight_rows[v][j] = weight_rows[v][j-1];
					end
					bone_rows[v][s]   = w.bone_index;
					weight_rows[v][s] = w.weight;
					placed = 1'b1;
				end
			end
		end
		r.bone_a       = bone_rows[v][0];
		r.bone_b       = bone_rows[v][1];
		r.bone_c       = bone_rows[v][2];
		r.bone_d       = bone_rows[v][3];
		r.weight_a     = weight_rows[v][0];
		r.weight_b     = weight_rows[v][1];
		r.weight_c     = weight_rows[v][2];
		r.weight_d     = weight_rows[v][3];
		r.was_inserted = placed;
		return r;
	endfunction

	task automatic check_field(string name, logic [WEIGHT_W-1:0] want, logic [WEIGHT_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_result(result_t want, result_t got);
		check_field("bone_a", WEIGHT_W'(want.bone_a), WEIGHT_W'(got.bone_a));
		check_field("bone_b", WEIGHT_W'(want.bone_b), WEIGHT_W'(got.bone_b));
		check_field("bone_c", WEIGHT_W'(want.bone_c), WEIGHT_W'(got.bone_c));
		check_field("bone_d", WEIGHT_W'(want.bone_d), WEIGHT_W'(got.bone_d));
		check_field("weight_a", want.weight_a, got.weight_a);
		check_field("weight_b", want.weight_b, got.weight_b);
		check_field("weight_c", want.weight_c, got.weight_c);
		check_field("weight_d", want.weight_d, got.weight_d);
		check_field("was_inserted", WEIGHT_W'(want.was_inserted), WEIGHT_W'(got.was_inserted));
	endtask

	always @(posedge clk) begin : watch
		stim_row_t note;
		result_t   predicted;
		if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					$error("result word with nothing expected");
					fail_count++;
				end else begin
					check_result(pending_results.pop_front(), result);
				end
			end
			if (start && !busy) begin
				note      = word_notes.pop_front();
				predicted = predict_word(item);
				pending_results = {pending_results, (note.fixed ? note.answer : predicted)};
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// returns at the edge that takes the word
	task automatic send_word(stim_row_t row, int idle_pct);
		word_notes = {word_notes, row};
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item  <= row.word;
		forever begin
			@(negedge clk);
			if (!busy) begin
				@(posedge clk);
				break;
			end
			@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	function automatic item_t random_word(int pool_base);
		item_t w;
		int pick;
		w.kind = ($urandom_range(99) < 25) ? KIND_READ : KIND_INSERT;
		pick = $urandom_range(99);
		if (pick < 85)
			w.vertex_index = VERTEX_W'(pool_base + int'($urandom_range(7)));
		else if (pick < 90)
			w.vertex_index = $urandom_range(1) ? 12'hFFF : 12'h000;
		else
			w.vertex_index = VERTEX_W'($urandom_range(NUM_VERTICES - 1));
		w.bone_index = BONE_W'($urandom_range(255));
		case ($urandom_range(9))
			0: w.weight = '0;
			1: w.weight = 16'hFFFF;
			2: w.weight = WEIGHT_W'($urandom_range(3));
			3, 4: w.weight = WEIGHT_W'($urandom_range(255));
			default: w.weight = WEIGHT_W'($urandom_range(65535));
		endcase
		return w;
	endfunction

	initial begin : stimulus
		int idle_by_phase [4];
		stim_row_t row;
		int ph;
		int n;
		idle_by_phase = '{0, 81, 0, 20};
		foreach (bone_rows[v, s]) begin
			bone_rows[v][s]   = '0;
			weight_rows[v][s] = '0;
		end
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < DIR_N; n++)
			send_word(DIR_ROWS[n], 0);
		wait_drained();

		for (ph = 0; ph < 4; ph++) begin
			for (n = 0; n < RAND_PER_PHASE; n++) begin
				row.word   = random_word(16 * ph + 8);
				row.fixed  = 1'b0;
				row.answer = '0;
				send_word(row, idle_by_phase[ph]);
			end
			// sender holds off until the pipe is empty
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: sim.f
sv/fbwt_pkg.sv
sv/fbwt_row_mem.sv
sv/fbwt_insert.sv
sv/top_four_bone_weight_table.sv
tb/sv/top_four_bone_weight_table_tb.sv
